// ===== src/swrd_pkg.sv =====
// Shared types and constants for the sliding window range detector.
`default_nettype none

package swrd_pkg;

    localparam int WINDOW_MAX = 1024;
    localparam int IDX_W      = $clog2(WINDOW_MAX);
    localparam int LEN_W      = 11;
    localparam int VAL_W      = 20;
    localparam int POS_W      = 32;
    localparam int CFG_W      = 20;

    typedef enum logic [0:0] {
        REG_WINDOW_LEN = 1'b0,
        REG_THRESHOLD  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [VAL_W-1:0] sample;
        logic             last_sample;
    } in_item_t;

    typedef struct packed {
        logic             window_full;
        logic             quiet;
        logic [POS_W-1:0] start_position;
        logic             none_found;
        logic             last_result;
    } out_item_t;

    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] pos;
    } entry_t;

    typedef struct packed {
        logic             clr;
        logic             dom_en;
        logic             shift;
        logic             insert;
        logic             is_min;
        logic [VAL_W-1:0] sample;
        logic [POS_W-1:0] ins_pos;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/swrd_cell.sv =====
// One cell of a monotonic store: holds one entry, shifts toward the front.
`default_nettype none

module swrd_cell (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire swrd_pkg::cell_ctl_t ctl,
    input  wire logic                prev_valid,
    input  wire swrd_pkg::entry_t    next_entry,
    output swrd_pkg::entry_t         entry
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [swrd_pkg::VAL_W-1:0] value_reg;
    logic [swrd_pkg::VAL_W-1:0] value_next;
    logic [swrd_pkg::POS_W-1:0] pos_reg;
    logic [swrd_pkg::POS_W-1:0] pos_next;
    logic                       dominated;

    assign dominated = ctl.is_min ? (ctl.sample <= value_reg) : (ctl.sample >= value_reg);

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        pos_next   = pos_reg;
        priority if (ctl.clr) begin
            valid_next = 1'b0;
        end else if (ctl.dom_en) begin
            valid_next = valid_reg && !dominated;
        end else if (ctl.shift) begin
            valid_next = next_entry.valid;
            value_next = next_entry.value;
            pos_next   = next_entry.pos;
        end else if (ctl.insert && prev_valid && !valid_reg) begin
            valid_next = 1'b1;
            value_next = ctl.sample;
            pos_next   = ctl.ins_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        pos_reg   <= pos_next;
    end

    assign entry.valid = valid_reg;
    assign entry.value = value_reg;
    assign entry.pos   = pos_reg;

endmodule

`default_nettype wire

// ===== src/swrd_store.sv =====
// Monotonic store: a chain of cells, front at cell 0, with front-pop decision.
`default_nettype none

module swrd_store (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire swrd_pkg::cell_ctl_t        ctl,
    input  wire logic                       drop_en,
    input  wire logic [swrd_pkg::LEN_W-1:0] mlen,
    input  wire logic [swrd_pkg::POS_W-1:0] cur_pos,
    output swrd_pkg::entry_t                front,
    output logic                            pop
);

    swrd_pkg::entry_t                     chain [swrd_pkg::WINDOW_MAX+1];
    logic [swrd_pkg::WINDOW_MAX-1:0]      occ;
    logic [swrd_pkg::WINDOW_MAX-1:0]      prev_v;
    swrd_pkg::cell_ctl_t                  cell_ctl;
    logic [swrd_pkg::LEN_W-1:0]           mlen_m1;
    logic                                 stale;
    logic                                 at_limit;

    assign chain[swrd_pkg::WINDOW_MAX] = '0;

    for (genvar i = 0; i < swrd_pkg::WINDOW_MAX; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign prev_v[i] = 1'b1;
        end else begin : g_body
            assign prev_v[i] = chain[i-1].valid;
        end
        assign occ[i] = chain[i].valid;

        swrd_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (cell_ctl),
            .prev_valid (prev_v[i]),
            .next_entry (chain[i+1]),
            .entry      (chain[i])
        );
    end

    assign front    = chain[0];
    assign mlen_m1  = mlen - swrd_pkg::LEN_W'(1);
    assign stale    = ({1'b0, front.pos} + (swrd_pkg::POS_W+1)'(mlen))
                      <= {1'b0, cur_pos};
    assign at_limit = occ[mlen_m1[swrd_pkg::IDX_W-1:0]];
    assign pop      = drop_en && front.valid && (stale || at_limit);

    always_comb begin
        cell_ctl       = ctl;
        cell_ctl.shift = pop;
    end

endmodule

`default_nettype wire

// ===== src/sliding_window_range_detector.sv =====
// Top level: sliding window min/max range detector built on two cell chains.
//
//  channel  | signals                           | direction | handshake
//  ---------+-----------------------------------+-----------+----------------
//  input    | s_valid, s_ready, s_data          | in        | valid/ready
//  result   | m_valid, m_ready, m_data          | out       | valid/ready
//  config   | cfg_wr_en, cfg_index, cfg_wdata   | in        | write, no wait
//
// A transaction is accepted in ST_IDLE, then stays in ST_DROP while either store
// drops front entries (usually 0 or 1, up to the old window length after
// window_len shrinks); each chain makes a single front-pop per cycle.
// Result register frees s_ready; a full result register stalls the finish, as does a pending front-pop.
// Reset clears control state and store occupancy; no clearing pass.
`default_nettype none

module sliding_window_range_detector (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire swrd_pkg::in_item_t         s_data,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output swrd_pkg::out_item_t             m_data,
    input  wire logic                       cfg_wr_en,
    input  wire swrd_pkg::cfg_reg_t         cfg_index,
    input  wire logic [swrd_pkg::CFG_W-1:0] cfg_wdata
);

    typedef enum logic {
        ST_IDLE,
        ST_DROP
    } state_t;

    localparam int PW = swrd_pkg::POS_W + 1;

    state_t                     state_reg,    state_next;
    logic [swrd_pkg::LEN_W-1:0] win_len_reg,  win_len_next;
    logic [swrd_pkg::VAL_W-1:0] thresh_reg,   thresh_next;
    logic [swrd_pkg::VAL_W-1:0] sample_reg,   sample_next;
    logic                       last_reg,     last_next;
    logic [swrd_pkg::POS_W-1:0] pos_reg,      pos_next;
    logic [swrd_pkg::LEN_W-1:0] mlen_reg,     mlen_next;
    logic [swrd_pkg::POS_W-1:0] count_reg,    count_next;
    logic                       anyq_reg,     anyq_next;
    logic                       m_valid_reg,  m_valid_next;
    swrd_pkg::out_item_t        m_data_reg,   m_data_next;

    swrd_pkg::cell_ctl_t        min_ctl;
    swrd_pkg::cell_ctl_t        max_ctl;
    swrd_pkg::entry_t           min_front;
    swrd_pkg::entry_t           max_front;
    logic                       pop_min;
    logic                       pop_max;
    logic                       accept;
    logic                       out_free;
    logic                       finish;
    logic                       drop_en;
    logic [swrd_pkg::LEN_W-1:0] mlen_clamped;
    logic [swrd_pkg::VAL_W-1:0] lo;
    logic [swrd_pkg::VAL_W-1:0] hi;
    logic [swrd_pkg::VAL_W-1:0] range_w;
    logic                       full;
    logic                       quiet;
    logic [PW-1:0]              start_sum;
    logic [swrd_pkg::POS_W-1:0] start_pos;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign drop_en  = (state_reg == ST_DROP);
    assign finish   = drop_en && !pop_min && !pop_max && out_free;

    always_comb begin
        if (win_len_reg == '0) begin
            mlen_clamped = swrd_pkg::LEN_W'(1);
        end else if (win_len_reg > swrd_pkg::LEN_W'(swrd_pkg::WINDOW_MAX)) begin
            mlen_clamped = swrd_pkg::LEN_W'(swrd_pkg::WINDOW_MAX);
        end else begin
            mlen_clamped = win_len_reg;
        end
    end

    always_comb begin
        min_ctl.clr     = finish && last_reg;
        min_ctl.dom_en  = accept;
        min_ctl.shift   = 1'b0;
        min_ctl.insert  = finish;
        min_ctl.is_min  = 1'b1;
        min_ctl.sample  = (state_reg == ST_IDLE) ? s_data.sample : sample_reg;
        min_ctl.ins_pos = pos_reg;
        max_ctl         = min_ctl;
        max_ctl.is_min  = 1'b0;
    end

    swrd_store u_min_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (min_ctl),
        .drop_en (drop_en),
        .mlen    (mlen_reg),
        .cur_pos (pos_reg),
        .front   (min_front),
        .pop     (pop_min)
    );

    swrd_store u_max_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (max_ctl),
        .drop_en (drop_en),
        .mlen    (mlen_reg),
        .cur_pos (pos_reg),
        .front   (max_front),
        .pop     (pop_max)
    );

    // empty store means the new sample becomes its front
    assign lo      = min_front.valid ? min_front.value : sample_reg;
    assign hi      = max_front.valid ? max_front.value : sample_reg;
    assign range_w = (hi >= lo) ? (hi - lo) : '0;
    assign full    = ({1'b0, pos_reg} + PW'(1)) >= PW'(mlen_reg);
    assign quiet   = full && (range_w <= thresh_reg);
    assign start_sum = {1'b0, pos_reg} + PW'(2) - PW'(mlen_reg);

    always_comb begin
        if (!full) begin
            start_pos = swrd_pkg::POS_W'(1);
        end else if (start_sum[swrd_pkg::POS_W]) begin
            start_pos = '1;
        end else begin
            start_pos = start_sum[swrd_pkg::POS_W-1:0];
        end
    end

    always_comb begin
        state_next   = state_reg;
        win_len_next = win_len_reg;
        thresh_next  = thresh_reg;
        sample_next  = sample_reg;
        last_next    = last_reg;
        pos_next     = pos_reg;
        mlen_next    = mlen_reg;
        count_next   = count_reg;
        anyq_next    = anyq_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                swrd_pkg::REG_WINDOW_LEN: win_len_next = cfg_wdata[swrd_pkg::LEN_W-1:0];
                swrd_pkg::REG_THRESHOLD:  thresh_next  = cfg_wdata[swrd_pkg::VAL_W-1:0];
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    sample_next = s_data.sample;
                    last_next   = s_data.last_sample;
                    pos_next    = count_reg;
                    mlen_next   = mlen_clamped;
                    state_next  = ST_DROP;
                end
            end
            ST_DROP: begin
                if (finish) begin
                    m_valid_next               = 1'b1;
                    m_data_next.window_full    = full;
                    m_data_next.quiet          = quiet;
                    m_data_next.start_position = start_pos;
                    m_data_next.none_found     = last_reg && !(anyq_reg || quiet);
                    m_data_next.last_result    = last_reg;
                    if (last_reg) begin
                        count_next = '0;
                        anyq_next  = 1'b0;
                    end else begin
                        count_next = (count_reg == '1) ? count_reg
                                                       : count_reg + swrd_pkg::POS_W'(1);
                        anyq_next  = anyq_reg || quiet;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            win_len_reg <= swrd_pkg::LEN_W'(1);
            thresh_reg  <= '0;
            count_reg   <= '0;
            anyq_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            win_len_reg <= win_len_next;
            thresh_reg  <= thresh_next;
            count_reg   <= count_next;
            anyq_reg    <= anyq_next;
            m_valid_reg <= m_valid_next;
            sample_reg  <= sample_next;
            last_reg    <= last_next;
            pos_reg     <= pos_next;
            mlen_reg    <= mlen_next;
            m_data_reg  <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction accepted while one is in flight");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        finish && last_reg |=> !min_front.valid && !max_front.valid
                               && count_reg == '0 && !anyq_reg)
        else $error("state not cleared after final transaction");

    a_none_found: assert property (@(posedge aclk) disable iff (!aresetn)
        finish && quiet |=> !m_data.none_found && m_data.window_full)
        else $error("quiet result flagged as none found");

endmodule

`default_nettype wire
